FILE: design/rs485_packet_deframer_macros.svh
// Assertion macros for the RS-485 packet deframer.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef RS485_PACKET_DEFRAMER_MACROS_SVH
`define RS485_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RPD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rpd_pkg.sv
// Shared types and constants for the RS-485 packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

    localparam int IDLE_W = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] SYNC_BYTE = 8'hEA;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // item kinds on the input side
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATION_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

    typedef enum logic [2:0] {
        ST_HUNT  = 3'd0,
        ST_ID    = 3'd1,
        ST_CMD   = 3'd2,
        ST_LEN_H = 3'd3,
        ST_LEN_L = 3'd4,
        ST_DATA  = 3'd5
    } parse_state_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_ABORT   = 2'd2
    } event_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: design/rpd_in_stage.sv
// Input register of the deframer: holds one accepted item until parsed.
// Depends on rpd_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module rpd_in_stage
    import rpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire item_t s_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    // accept while empty or while the held item moves on this cycle
    assign s_tready = !valid_reg || take;

    // track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // capture the item payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

FILE: design/rpd_parse.sv
// Frame parser: state machine, held header fields, idle counter, config.
// Depends on rpd_pkg for state, item and result types.
`timescale 1ns / 1ps
`default_nettype none

module rpd_parse
    import rpd_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 proc,
    input  wire item_t                item,
    output logic                      res_valid,
    output result_t                   res
);

    localparam int LIMIT_W = 8 + $clog2(TICKS_PER_SECOND + 1);
    localparam int CMP_W = (LIMIT_W > IDLE_W) ? LIMIT_W : IDLE_W;

    parse_state_t        state_reg, state_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [15:0]         len_reg, len_next;
    logic [15:0]         count_reg, count_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;
    logic [IDLE_W-1:0]   idle_inc;
    logic [7:0]          station_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [15:0]         len_full;
    logic [16:0]         idx_plus;
    logic                timed_out;

    // configuration: keep the id and the timeout already scaled to ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= 8'd0;
            limit_reg   <= LIMIT_W'(TICKS_PER_SECOND);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_STATION_ID)
            begin
                station_reg <= cfg_data;
            end
            else if (cfg_index == REG_TIMEOUT)
            begin
                limit_reg <= LIMIT_W'(cfg_data) * LIMIT_W'(TICKS_PER_SECOND);
            end
        end
    end

    // parser state and held frame fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            cmd_reg   <= 8'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
            idle_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            idle_reg  <= idle_next;
        end
    end

    // saturating idle count and timeout compare
    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign timed_out = CMP_W'(idle_inc) > CMP_W'(limit_reg);
    assign len_full  = {len_reg[15:8], item.rx_byte};
    assign idx_plus  = {1'b0, count_reg} + 17'd1;

    // next state and result
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res.event_res = EV_PAYLOAD;
        res.byte_index = 16'd0;
        res.data_byte = 8'd0;
        res.last      = 1'b1;

        if (proc)
        begin
            if (item.command == CMD_TICK)
            begin
                idle_next = idle_inc;
                if (state_reg != ST_HUNT && timed_out)
                begin
                    state_next     = ST_HUNT;
                    idle_next      = '0;
                    res_valid      = 1'b1;
                    res.event_res  = EV_ABORT;
                    res.byte_index = count_reg;
                end
            end
            else
            begin
                idle_next = '0;
                unique case (state_reg)
                    ST_HUNT:
                    begin
                        if (item.rx_byte == SYNC_BYTE)
                        begin
                            state_next = ST_ID;
                        end
                    end
                    ST_ID:
                    begin
                        state_next = (item.rx_byte == station_reg) ? ST_CMD : ST_HUNT;
                    end
                    ST_CMD:
                    begin
                        cmd_next   = item.rx_byte;
                        state_next = ST_LEN_H;
                    end
                    ST_LEN_H:
                    begin
                        len_next   = {item.rx_byte, 8'd0};
                        count_next = 16'd0;
                        state_next = ST_LEN_L;
                    end
                    ST_LEN_L:
                    begin
                        len_next   = len_full;
                        count_next = 16'd0;
                        if (len_full == 16'd0)
                        begin
                            state_next    = ST_HUNT;
                            res_valid     = 1'b1;
                            res.event_res = EV_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_DATA;
                        end
                    end
                    ST_DATA:
                    begin
                        count_next     = idx_plus[15:0];
                        res_valid      = 1'b1;
                        res.event_res  = EV_PAYLOAD;
                        res.byte_index = count_reg;
                        res.data_byte  = item.rx_byte;
                        res.last       = idx_plus >= {1'b0, len_reg};
                        if (res.last)
                        begin
                            state_next = ST_HUNT;
                        end
                    end
                    default:
                    begin
                        // undefined codes parse as hunting
                        state_next = (item.rx_byte == SYNC_BYTE) ? ST_ID : ST_HUNT;
                    end
                endcase
            end
        end

        res.frame_command = cmd_next;
        res.frame_length  = len_next;
    end

endmodule

`default_nettype wire

FILE: design/rpd_out_stage.sv
// Output register of the deframer: holds one result until taken downstream.
// Depends on rpd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module rpd_out_stage
    import rpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      m_res
);

    logic    valid_reg;
    result_t res_reg;

    // room for a new result this cycle
    assign free = !valid_reg || m_tready;

    // load on a parsed item, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // capture result payload
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res = res_reg;

endmodule

`default_nettype wire

FILE: design/rs485_packet_deframer.sv
// Top level of the RS-485 packet deframer: input register, parser, output register.
// Depends on rpd_pkg, rpd_in_stage, rpd_parse, rpd_out_stage and the macros header.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: command; tdata: rx_byte
//  m_      | out | m_tvalid/m_tready  | tuser: event_res; tlast: last; tdata: header+data
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while m_tready is high; a result passes the input
//  register and the parser and is held in the output register until it is taken.
//  The rate is set by the parser state loop, which closes once per item.
//  Reset is asynchronous; it clears the parser to hunting and loads the default
//  timeout. A low m_tready holds the result; the input register then keeps one
//  item and s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "rs485_packet_deframer_macros.svh"

module rs485_packet_deframer
    import rpd_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  wire logic                 s_tuser,   // [0] command
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,   // [7:0] frame_command, [23:8] frame_length,
                                                 // [39:24] byte_index, [47:40] data_byte
    output logic [1:0]                m_tuser,   // [1:0] event_res
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    proc;
    logic    res_valid;
    result_t res;
    result_t m_res;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    assign s_item.command = s_tuser;
    assign s_item.rx_byte = s_tdata;

    // parse the held item whenever the output register has room
    assign proc = item_valid && out_free;

    rpd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (proc),
        .item_valid (item_valid),
        .item       (item)
    );

    rpd_parse #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .proc      (proc),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rpd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // pack the result fields
    assign m_tdata = {m_res.data_byte, m_res.byte_index, m_res.frame_length,
                      m_res.frame_command};
    assign m_tuser = m_res.event_res;
    assign m_tlast = m_res.last;

    // empty-frame and abort results always close the frame
    `RPD_ASSERT_IMPLIES(a_close_last,
        m_tvalid && (m_tuser == EV_EMPTY || m_tuser == EV_ABORT), m_tlast,
        "empty or abort result without last")

    // a payload byte lies inside its declared length
    `RPD_ASSERT_IMPLIES(a_index_in_len,
        m_tvalid && m_tuser == EV_PAYLOAD, m_tdata[39:24] < m_tdata[23:8],
        "payload index beyond frame length")

    // a parsed item with a result shows up on the output next cycle
    `RPD_ASSERT_NEXT(a_result_lands, proc && res_valid, m_tvalid,
        "parsed result not presented")

endmodule

`default_nettype wire
